// ===== design/bbcm_pkg.sv =====
// Shared constants and types for the clipped box blur unit.
`default_nettype none
package bbcm_pkg;
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_RADIUS = 5;
	localparam int MAX_HEIGHT     = 4096;
	localparam int FW_BITS        = 12;
	localparam int FH_BITS        = 13;
	localparam int RAD_BITS       = 3;
	localparam int ROW_BITS       = 12;
	localparam int COL_OUT_BITS   = 11;
	localparam int PIX_BITS       = 24;

	localparam logic [11:0] RST_WIDTH  = 12'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;
	localparam logic [2:0]  RST_RADIUS = 3'd5;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;
endpackage
`default_nettype wire

// ===== design/box_blur_clipped_mean_unit.sv =====
// Top level of the clipped box blur unit: control, window summing and division.
// Pixels enter in raster order and are kept in a ring of 2*MAX_RADIUS+2 rows in one
// RAM. Each output pixel is produced by reading its clipped window from that RAM one
// pixel per cycle and then dividing the three sums by the window count with three
// restoring dividers in parallel, one quotient bit per cycle. The input stream is not
// ready from the window read until the result is loaded into the output register; an
// item without a result is taken while idle. The first result appears once radius rows
// plus radius+1 pixels of the next row have been received, and drain words (tuser high)
// after the frame flush the rest. A register write restarts the frame.
`default_nettype none
module box_blur_clipped_mean_unit #(
	parameter int MAX_WIDTH  = bbcm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = bbcm_pkg::DEF_MAX_RADIUS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  wire logic        s_tuser,   // operation
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // red_out, green_out, blue_out, out_row, out_col, pad
	output logic             m_tlast    // frame_done
);
	import bbcm_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int RB    = $clog2(RING);
	localparam int AW    = RB + CW;
	localparam int DEPTH = RING << CW;
	localparam int RDW   = $clog2(MAX_RADIUS + 1);
	localparam int NW    = $clog2(2 * MAX_RADIUS + 2);
	localparam int NWIN  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int KW    = $clog2(NWIN + 1);
	localparam int SW    = $clog2(255 * NWIN + 1);
	localparam int LW    = CW + ROW_BITS + 1;
	localparam int DCW   = $clog2(SW + 1);

	state_t state_q;

	logic [FW_BITS-1:0]  frame_width_q;
	logic [FH_BITS-1:0]  frame_height_q;
	logic [RAD_BITS-1:0] radius_q;

	logic [CW:0]        w_eff;
	logic [FH_BITS-1:0] h_eff;
	logic [RDW-1:0]     r_eff;
	logic [LW-1:0]      delay;

	logic [CW-1:0]       in_col_q;
	logic [ROW_BITS-1:0] in_row_q;
	logic [RB-1:0]       in_ring_q;
	logic [LW-1:0]       lin_q;
	logic                complete_q;
	logic [ROW_BITS-1:0] orow_q;
	logic [CW-1:0]       ocol_q;
	logic [RB-1:0]       out_ring_q;

	logic [RB-1:0]  y_ring_q;
	logic [NW-1:0]  rows_left_q;
	logic [CW-1:0]  x_q, c0_q, c1_q;
	logic [KW-1:0]  cnt_q;
	logic           issue_q;
	logic           rd_s2, last_s2;
	logic [SW-1:0]  sum_q [3];
	logic [KW:0]    rem_q [3];
	logic [DCW-1:0] div_cnt_q;

	logic [PIX_BITS-1:0] rdata;
	logic                cfg_wr, in_fire, out_fire, pix_wr, start_emit;

	// effective register values
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = FH_BITS'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = FH_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
		r_eff = (32'(radius_q) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius_q);
		delay = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
	end

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign pix_wr   = in_fire && (s_tuser == OP_PIXEL) && !complete_q;
	assign start_emit = in_fire &&
		((s_tuser == OP_DRAIN) ? complete_q : (!complete_q && lin_q >= delay));

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(frame_width_q);
			REG_HEIGHT: prdata = 32'(frame_height_q);
			REG_RADIUS: prdata = 32'(radius_q);
			default:    prdata = '0;
		endcase
	end

	// window bounds of the next output pixel
	logic [ROW_BITS-1:0] r0;
	logic [ROW_BITS:0]   r1, rsum;
	logic [CW:0]         c0, c1, csum;
	logic [NW-1:0]       nrow, ncol;
	logic [RDW-1:0]      dr;
	logic [RB:0]         ring0;

	always_comb begin
		r0   = (orow_q > ROW_BITS'(r_eff)) ? orow_q - ROW_BITS'(r_eff) : '0;
		rsum = (ROW_BITS+1)'(orow_q) + (ROW_BITS+1)'(r_eff);
		r1   = (rsum < (ROW_BITS+1)'(h_eff)) ? rsum : (ROW_BITS+1)'(h_eff - 1'b1);
		c0   = ((CW+1)'(ocol_q) > (CW+1)'(r_eff)) ? (CW+1)'(ocol_q) - (CW+1)'(r_eff) : '0;
		csum = (CW+1)'(ocol_q) + (CW+1)'(r_eff);
		c1   = (csum < w_eff) ? csum : w_eff - 1'b1;
		nrow = NW'(r1 - (ROW_BITS+1)'(r0) + 1'b1);
		ncol = NW'(c1 - c0 + 1'b1);
		dr   = RDW'(orow_q - r0);
		ring0 = ((RB+1)'(out_ring_q) >= (RB+1)'(dr)) ?
			(RB+1)'(out_ring_q) - (RB+1)'(dr) :
			(RB+1)'(out_ring_q) + (RB+1)'(RING) - (RB+1)'(dr);
	end

	logic [AW-1:0] waddr, raddr;
	assign waddr = {in_ring_q, in_col_q};
	assign raddr = {y_ring_q, x_q};

	bbcm_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_row_store (
		.clk   (clk),
		.we    (pix_wr),
		.waddr (waddr),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic last_issue;
	assign last_issue = (rows_left_q == NW'(1)) && (x_q == c1_q);

	logic [KW:0] trial [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i][KW-1:0], sum_q[i][SW-1]};
		end
	end

	logic frame_end;
	assign frame_end = ((ROW_BITS+1)'(orow_q) == (ROW_BITS+1)'(h_eff - 1'b1)) &&
		((CW+1)'(ocol_q) == w_eff - 1'b1);

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frame_width_q  <= RST_WIDTH;
			frame_height_q <= RST_HEIGHT;
			radius_q       <= RST_RADIUS;
			in_col_q       <= '0;
			in_row_q       <= '0;
			in_ring_q      <= '0;
			lin_q          <= '0;
			complete_q     <= 1'b0;
			orow_q         <= '0;
			ocol_q         <= '0;
			out_ring_q     <= '0;
			issue_q        <= 1'b0;
			rd_s2          <= 1'b0;
			last_s2        <= 1'b0;
			m_tvalid       <= 1'b0;
		end else begin
			if (out_load && !cfg_wr) begin
				m_tvalid <= 1'b1;
			end else if (out_fire) begin
				m_tvalid <= 1'b0;
			end
			rd_s2   <= issue_q && (state_q == ST_SUM);
			last_s2 <= last_issue;

			if (cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
					paddr[3:2] == REG_RADIUS)) begin
				unique case (paddr[3:2])
					REG_WIDTH:  frame_width_q  <= pwdata[FW_BITS-1:0];
					REG_HEIGHT: frame_height_q <= pwdata[FH_BITS-1:0];
					REG_RADIUS: radius_q       <= pwdata[RAD_BITS-1:0];
					default:    ;
				endcase
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_ring_q  <= '0;
				lin_q      <= '0;
				complete_q <= 1'b0;
				orow_q     <= '0;
				ocol_q     <= '0;
				out_ring_q <= '0;
			end else begin
				if (pix_wr) begin
					lin_q <= lin_q + 1'b1;
					if ((CW+1)'(in_col_q) + 1'b1 >= w_eff) begin
						in_col_q <= '0;
						if ((ROW_BITS+1)'(in_row_q) + 1'b1 >= (ROW_BITS+1)'(h_eff)) begin
							complete_q <= 1'b1;
						end else begin
							in_row_q  <= in_row_q + 1'b1;
							in_ring_q <= (in_ring_q == RB'(RING - 1)) ? '0 : in_ring_q + 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end

				unique case (state_q)
					ST_IDLE: begin
						if (start_emit) begin
							state_q <= ST_SETUP;
						end
					end
					ST_SETUP: begin
						y_ring_q    <= RB'(ring0);
						rows_left_q <= nrow;
						x_q         <= CW'(c0);
						c0_q        <= CW'(c0);
						c1_q        <= CW'(c1);
						cnt_q       <= KW'(nrow) * KW'(ncol);
						issue_q     <= 1'b1;
						state_q     <= ST_SUM;
					end
					ST_SUM: begin
						if (issue_q) begin
							if (last_issue) begin
								issue_q <= 1'b0;
							end
							if (x_q == c1_q) begin
								x_q         <= c0_q;
								rows_left_q <= rows_left_q - 1'b1;
								y_ring_q    <= (y_ring_q == RB'(RING - 1)) ? '0 : y_ring_q + 1'b1;
							end else begin
								x_q <= x_q + 1'b1;
							end
						end
						if (rd_s2 && last_s2) begin
							div_cnt_q <= DCW'(SW);
							state_q   <= ST_DIV;
						end
					end
					ST_DIV: begin
						div_cnt_q <= div_cnt_q - 1'b1;
						if (div_cnt_q == DCW'(1)) begin
							state_q <= ST_OUT;
						end
					end
					ST_OUT: begin
						if (out_load) begin
							state_q <= ST_IDLE;
							if (frame_end) begin
								in_col_q   <= '0;
								in_row_q   <= '0;
								in_ring_q  <= '0;
								lin_q      <= '0;
								complete_q <= 1'b0;
								orow_q     <= '0;
								ocol_q     <= '0;
								out_ring_q <= '0;
							end else if ((CW+1)'(ocol_q) + 1'b1 >= w_eff) begin
								ocol_q     <= '0;
								orow_q     <= orow_q + 1'b1;
								out_ring_q <= (out_ring_q == RB'(RING - 1)) ? '0 : out_ring_q + 1'b1;
							end else begin
								ocol_q <= ocol_q + 1'b1;
							end
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// Sums, divider and output word; no reset needed on these.
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				rem_q[i] <= '0;
			end
		end else if (state_q == ST_SUM && rd_s2) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SW'(rdata[8*i +: 8]);
			end
		end else if (state_q == ST_DIV) begin
			// Restoring division: the sum register shifts out dividend bits and
			// collects quotient bits.
			for (int i = 0; i < 3; i++) begin
				if (trial[i] >= (KW+1)'(cnt_q)) begin
					rem_q[i] <= trial[i] - (KW+1)'(cnt_q);
					sum_q[i] <= {sum_q[i][SW-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[i];
					sum_q[i] <= {sum_q[i][SW-2:0], 1'b0};
				end
			end
		end
		if (out_load) begin
			m_tdata <= {1'b0, COL_OUT_BITS'(ocol_q), orow_q,
				sum_q[2][7:0], sum_q[1][7:0], sum_q[0][7:0]};
			m_tlast <= frame_end;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("window count is zero during division");

	a_early_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser == OP_DRAIN && !complete_q && !cfg_wr) |=> state_q == ST_IDLE)
		else $error("early drain started a result");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!m_tvalid || m_tready) && frame_end && !cfg_wr)
		|=> (lin_q == '0 && !complete_q && m_tlast))
		else $error("frame end did not restart positions");

	a_one_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && issue_q) |-> rows_left_q != '0)
		else $error("window read ran past its last row");
endmodule
`default_nettype wire

// ===== design/bbcm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bbcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
